FILE: hw/rtl/utf8_or_sjis_code_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_OR_SJIS_CODE_DECODER_MACROS_SVH
`define UTF8_OR_SJIS_CODE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8SJ_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8SJ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/u8sj_pkg.sv
package u8sj_pkg;

   localparam int CODE_BITS     = 16;
   localparam int REQ_DATA_BITS = 48;
   localparam int PARTIAL_BITS  = 21;

   localparam logic [CODE_BITS-1:0] BAD_CODE = 16'h30fb;

   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_TEXT_BYTE   = 1'b1;

   // Results of one accepted text byte, handed to the output stage.
   typedef struct packed {
      logic                 valid;     // at least one result
      logic                 two;       // error word followed by a second result
      logic                 from_mem;  // first result comes from the code table
      logic [CODE_BITS-1:0] code0;
      logic [CODE_BITS-1:0] code1;
   } u8sj_res_type;

   typedef struct packed {
      logic                    opens;
      logic [CODE_BITS-1:0]    code;
      logic [PARTIAL_BITS-1:0] partial;
      logic [1:0]              pending;
   } u8sj_lead_type;

   // UTF-8 lead byte decode: either a result or an opened sequence.
   function automatic u8sj_lead_type utf8_lead(input logic [7:0] b,
                                               input logic [1:0] after);
      u8sj_lead_type r;
      logic [2:0]    count;
      r     = '0;
      count = 3'd0;
      if (!b[7]) begin
         r.code = {8'h00, b};
      end else begin
         if ((b & 8'he0) == 8'hc0) begin
            count = 3'd2;
         end else if ((b & 8'hf0) == 8'he0) begin
            count = 3'd3;
         end else if ((b & 8'hf8) == 8'hf0) begin
            count = 3'd4;
         end
         if (count == 3'd0 || {1'b0, after} < (count - 3'd1)) begin
            r.code = BAD_CODE;
         end else begin
            r.opens   = 1'b1;
            r.pending = 2'(count - 3'd1);
            case (count)
               3'd2:    r.partial = {16'h0000, b[4:0]};
               3'd3:    r.partial = {17'h00000, b[3:0]};
               default: r.partial = {18'h00000, b[2:0]};
            endcase
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/u8sj_table.sv
module u8sj_table #(
   parameter int TABLE_ADDR_BITS = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [TABLE_ADDR_BITS-1:0]     wr_addr,
   input  logic [u8sj_pkg::CODE_BITS-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [TABLE_ADDR_BITS-1:0]     rd_addr,
   output logic [u8sj_pkg::CODE_BITS-1:0] rd_data
);
   import u8sj_pkg::*;

   localparam int DEPTH = 2 ** TABLE_ADDR_BITS;

   logic [CODE_BITS-1:0] table_mem [DEPTH];
   logic [CODE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/u8sj_decode.sv
module u8sj_decode #(
   parameter int TABLE_ADDR_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic                         op,
   input  logic [7:0]                   text_byte,
   input  logic [1:0]                   bytes_after,
   input  logic                         cfg_we,
   input  logic                         cfg_mode,
   output u8sj_pkg::u8sj_res_type       res,
   output logic                         rd_en,
   output logic [TABLE_ADDR_BITS-1:0]   rd_addr
);
   import u8sj_pkg::*;

   logic                    mode_ff;
   logic [PARTIAL_BITS-1:0] partial_ff, partial_in;
   logic [1:0]              pending_ff, pending_in;
   logic [7:0]              lead_ff, lead_in;
   logic                    waiting_ff, waiting_in;

   u8sj_lead_type           lead_dec;
   logic [PARTIAL_BITS-1:0] shifted;
   logic [15:0]             addr_full;
   logic                    step;

   assign step = take && (op == OP_TEXT_BYTE);

   always_comb begin
      res        = '0;
      partial_in = partial_ff;
      pending_in = pending_ff;
      lead_in    = lead_ff;
      waiting_in = waiting_ff;
      addr_full  = {8'h00, text_byte};
      lead_dec   = utf8_lead(text_byte, bytes_after);
      shifted    = {partial_ff[PARTIAL_BITS-7:0], text_byte[5:0]};
      if (mode_ff) begin
         if (pending_ff == 2'd0) begin
            if (lead_dec.opens) begin
               partial_in = lead_dec.partial;
               pending_in = lead_dec.pending;
            end else begin
               res.valid = 1'b1;
               res.code0 = lead_dec.code;
            end
         end else if (text_byte[7:6] != 2'b10) begin
            // broken sequence: error word, then the byte again as a lead
            res.valid  = 1'b1;
            res.code0  = BAD_CODE;
            partial_in = '0;
            pending_in = 2'd0;
            if (lead_dec.opens) begin
               partial_in = lead_dec.partial;
               pending_in = lead_dec.pending;
            end else begin
               res.two   = 1'b1;
               res.code1 = lead_dec.code;
            end
         end else begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               res.valid  = 1'b1;
               res.code0  = (shifted[PARTIAL_BITS-1:CODE_BITS] == '0) ?
                            shifted[CODE_BITS-1:0] : BAD_CODE;
               partial_in = '0;
            end else begin
               partial_in = shifted;
            end
         end
      end else begin
         if (waiting_ff) begin
            addr_full    = {lead_ff, text_byte};
            res.valid    = 1'b1;
            res.from_mem = 1'b1;
            waiting_in   = 1'b0;
            lead_in      = 8'h00;
         end else if (text_byte inside {[8'h81:8'h9f], [8'he0:8'hfc]}) begin
            if (bytes_after == 2'd0) begin
               res.valid = 1'b1;
               res.code0 = BAD_CODE;
            end else begin
               lead_in    = text_byte;
               waiting_in = 1'b1;
            end
         end else begin
            res.valid    = 1'b1;
            res.from_mem = 1'b1;
         end
      end
   end

   assign rd_addr = addr_full[TABLE_ADDR_BITS-1:0];
   assign rd_en   = step && res.from_mem;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         partial_ff <= '0;
         pending_ff <= 2'd0;
         lead_ff    <= 8'h00;
         waiting_ff <= 1'b0;
      end else if (cfg_we) begin
         mode_ff    <= cfg_mode;
         partial_ff <= '0;
         pending_ff <= 2'd0;
         lead_ff    <= 8'h00;
         waiting_ff <= 1'b0;
      end else if (step) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
         lead_ff    <= lead_in;
         waiting_ff <= waiting_in;
      end
   end

endmodule

FILE: hw/rtl/utf8_or_sjis_code_decoder.sv
// Timing: an accepted word is registered into s1, then its first result into the
// output register, from which rsp_ presents it.
// Throughput: one word per cycle while rsp_tready stays high; a broken UTF-8 sequence
// that also yields a second result holds the input while both words drain.
// The code table RAM is read once per Shift-JIS lookup and written once per load.
// Reset: synchronous, active high; clears decode state, mode and valids, not the table.
`include "utf8_or_sjis_code_decoder_macros.svh"
module utf8_or_sjis_code_decoder #(
   parameter int TABLE_ADDR_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, low bit up: table_index[15:0], table_value[31:16],
   // text_byte[39:32], bytes_after[41:40], zero pad [47:42]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [u8sj_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,   // op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [u8sj_pkg::CODE_BITS-1:0]     rsp_tdata,   // code_point
   output logic                               rsp_tlast,   // last_of_item
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data     // utf8_mode
);
   import u8sj_pkg::*;

   // input word fields
   logic [15:0] table_index;
   logic [15:0] table_value;
   logic [7:0]  text_byte;
   logic [1:0]  bytes_after;

   assign table_index = req_tdata[15:0];
   assign table_value = req_tdata[31:16];
   assign text_byte   = req_tdata[39:32];
   assign bytes_after = req_tdata[41:40];

   logic take;
   logic cfg_we;

   u8sj_res_type               dec_res;
   logic                       rd_en;
   logic [TABLE_ADDR_BITS-1:0] rd_addr;
   logic [CODE_BITS-1:0]       rd_data;

   // result stage (s1): holds the decoded word while the table read completes
   u8sj_res_type s1_res_ff, s1_res_in;
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_phase_ff, s1_phase_in;   // first of two results already sent

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0] rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic out_free;
   logic s1_send;
   logic s1_done;
   logic s1_ready;

   // Mode writes must arrive only while idle (not enforced here); the port never pushes back.
   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_send    = s1_valid_ff && out_free;
   assign s1_done    = s1_send && (!s1_res_ff.two || s1_phase_ff);
   assign s1_ready   = !s1_valid_ff || s1_done;
   assign req_tready = s1_ready;
   assign take       = req_tvalid && s1_ready;

   u8sj_decode #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .op          (req_tuser),
      .text_byte   (text_byte),
      .bytes_after (bytes_after),
      .cfg_we      (cfg_we),
      .cfg_mode    (csr_data),
      .res         (dec_res),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   // At most one access per accepted word (load or lookup), so a read never meets a
   // write in the same cycle; a load is visible to the very next lookup.
   u8sj_table #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (take && (req_tuser == OP_TABLE_WRITE)),
      .wr_addr (table_index[TABLE_ADDR_BITS-1:0]),
      .wr_data (table_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // s1 control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_res_in   = s1_res_ff;
      s1_phase_in = s1_phase_ff;
      if (take) begin
         s1_valid_in = (req_tuser == OP_TEXT_BYTE) && dec_res.valid;
         s1_res_in   = dec_res;
         s1_phase_in = 1'b0;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_phase_in = 1'b0;
      end else if (s1_send) begin
         s1_phase_in = 1'b1;
      end
   end

   // output register load; table data is held since no new read issues
   // until s1 drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_send) begin
         rsp_valid_in = 1'b1;
         if (s1_phase_ff) begin
            rsp_code_in = s1_res_ff.code1;
         end else if (s1_res_ff.from_mem) begin
            rsp_code_in = rd_data;
         end else begin
            rsp_code_in = s1_res_ff.code0;
         end
         rsp_last_in = !s1_res_ff.two || s1_phase_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_res_ff   <= s1_res_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

   `U8SJ_ASSERT_SAME(a_phase_two, clock, reset, s1_phase_ff,
      s1_valid_ff && s1_res_ff.two, "second-result phase without a two-result word")
   `U8SJ_ASSERT_SAME(a_mem_single, clock, reset, s1_valid_ff && s1_res_ff.from_mem,
      !s1_res_ff.two, "table lookup marked with two results")
   `U8SJ_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tlast, "second result did not follow the error word")

endmodule
